// ===== rtl/core/timing_wheel_scheduler_macros.svh =====
// assertion macros shared by the timing wheel scheduler rtl
`ifndef TIMING_WHEEL_SCHEDULER_MACROS_SVH
`define TIMING_WHEEL_SCHEDULER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TWS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tws_pkg.sv =====
// types and constants of the timing wheel scheduler
`default_nettype none

package tws_pkg;

    localparam int TAG_W   = 10;
    localparam int DELAY_W = 8;

    typedef logic [TAG_W-1:0] t_tag;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_SCHEDULE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_APP_RD,
        ST_APP_WR,
        ST_TICK_RD,
        ST_TICK_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/tws_if.sv =====
// valid/ready channel interfaces of the timing wheel scheduler
`default_nettype none

interface tws_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [tws_pkg::TAG_W-1:0]     ident;
    logic [tws_pkg::DELAY_W-1:0]   delay;

    modport source (output valid, output op, output ident, output delay, input ready);
    modport sink   (input valid, input op, input ident, input delay, output ready);
endinterface

interface tws_out_if;
    logic                          valid;
    logic                          ready;
    logic [tws_pkg::TAG_W-1:0]     expired_ident;
    logic                          last;

    modport source (output valid, output expired_ident, output last, input ready);
    modport sink   (input valid, input expired_ident, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/timing_wheel_scheduler.sv =====
// timing wheel scheduler: slot rows in one memory, scanned by a shared row compare unit
//
//   channel  dir  beat payload              role
//   i_in     in   op, ident, delay          tick or schedule request
//   o_out    out  expired_ident, last       one fired identifier per beat
//
// schedule: the removal scan reads one slot row per cycle through the single memory
//   read port and stops early at the first match
// tick: reads the current slot row, then fires its identifiers one per beat,
//   slowed by output stalls; an empty slot just moves the current slot on
// after reset a clearing pass writes every row before i_in is ready
// the output register lets a finished beat wait while the next request is taken
`default_nettype none
`include "timing_wheel_scheduler_macros.svh"

module timing_wheel_scheduler #(
    parameter int SLOTS            = 64,
    parameter int ENTRIES_PER_SLOT = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tws_in_if.sink     i_in,
    tws_out_if.source  o_out
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ENT_W  = (ENTRIES_PER_SLOT > 1) ? $clog2(ENTRIES_PER_SLOT) : 1;
    localparam int TAG_W  = tws_pkg::TAG_W;

    localparam logic [SLOT_W:0]   C_SLOTS   = (SLOT_W+1)'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [ENT_W-1:0]  LAST_ENT  = ENT_W'(ENTRIES_PER_SLOT - 1);

    typedef tws_pkg::t_tag [ENTRIES_PER_SLOT-1:0] t_row;

    // delay mod SLOTS by restoring remainder, one bit per step
    function automatic logic [SLOT_W-1:0] f_mod_slots(input logic [tws_pkg::DELAY_W-1:0] d);
        logic [SLOT_W:0]   t;
        logic [SLOT_W-1:0] rem;
        rem = '0;
        for (int i = tws_pkg::DELAY_W - 1; i >= 0; i--) begin
            t = {rem, d[i]};
            if (t >= C_SLOTS) begin
                t = t - C_SLOTS;
            end
            rem = t[SLOT_W-1:0];
        end
        return rem;
    endfunction

    t_row r_mem [SLOTS];
    t_row r_rd_data;

    tws_pkg::t_state   r_state, n_state;
    logic [SLOT_W-1:0] r_scan, n_scan;
    logic [SLOT_W-1:0] r_chk, n_chk;
    logic              r_pend, n_pend;
    logic [SLOT_W-1:0] r_cur, n_cur;
    tws_pkg::t_tag     r_tag, n_tag;
    logic [SLOT_W-1:0] r_dmod, n_dmod;
    logic [ENT_W-1:0]  r_idx, n_idx;
    logic              r_out_vld, n_out_vld;
    tws_pkg::t_tag     r_out_ident, n_out_ident;
    logic              r_out_last, n_out_last;

    logic              w_accept;
    logic              w_hit_any;
    logic [ENT_W-1:0]  w_hit_idx;
    t_row              w_shift;
    t_row              w_removed;
    logic              w_free_any;
    logic [ENT_W-1:0]  w_free_idx;
    t_row              w_appended;
    logic [SLOT_W:0]   w_sum;
    logic [SLOT_W:0]   w_sum_adj;
    logic [SLOT_W-1:0] w_target;
    logic [SLOT_W-1:0] w_cur_next;
    tws_pkg::t_tag     w_sel_ent;
    tws_pkg::t_tag     w_next_ent;
    logic              w_cur_nz;
    logic              w_last;
    logic              w_out_free;
    logic              w_load;
    logic              w_rd_en;
    logic [SLOT_W-1:0] w_rd_addr;
    logic              w_wr_en;
    logic [SLOT_W-1:0] w_wr_addr;
    t_row              w_wr_data;

    assign i_in.ready          = (r_state == tws_pkg::ST_IDLE);
    assign w_accept            = i_in.valid && i_in.ready;
    assign o_out.valid         = r_out_vld;
    assign o_out.expired_ident = r_out_ident;
    assign o_out.last          = r_out_last;

    // row compare unit: first match, first free entry, gap closing
    assign w_shift = r_rd_data >> TAG_W;

    always_comb begin
        w_hit_any  = 1'b0;
        w_hit_idx  = '0;
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int k = ENTRIES_PER_SLOT - 1; k >= 0; k--) begin
            if (r_rd_data[k] == r_tag) begin
                w_hit_any = 1'b1;
                w_hit_idx = ENT_W'(k);
            end
            if (r_rd_data[k] == '0) begin
                w_free_any = 1'b1;
                w_free_idx = ENT_W'(k);
            end
        end
    end

    always_comb begin
        w_sel_ent  = '0;
        w_next_ent = '0;
        for (int k = 0; k < ENTRIES_PER_SLOT; k++) begin
            w_removed[k]  = (ENT_W'(k) < w_hit_idx) ? r_rd_data[k] : w_shift[k];
            w_appended[k] = (ENT_W'(k) == w_free_idx) ? r_tag : r_rd_data[k];
            if (ENT_W'(k) == r_idx) begin
                w_sel_ent  = r_rd_data[k];
                w_next_ent = w_shift[k];
            end
        end
    end

    assign w_sum      = {1'b0, r_cur} + {1'b0, r_dmod};
    assign w_sum_adj  = w_sum - C_SLOTS;
    assign w_target   = (w_sum >= C_SLOTS) ? w_sum_adj[SLOT_W-1:0] : w_sum[SLOT_W-1:0];
    assign w_cur_next = (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;

    assign w_cur_nz   = (w_sel_ent != '0);
    assign w_last     = (r_idx == LAST_ENT) || (w_next_ent == '0);
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_load     = (r_state == tws_pkg::ST_TICK_EMIT) && w_cur_nz && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tws_pkg::ST_CLEAR: begin
                if (r_scan == LAST_SLOT) begin
                    n_state = tws_pkg::ST_IDLE;
                end
            end
            tws_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.op == tws_pkg::OP_TICK) begin
                        n_state = tws_pkg::ST_TICK_RD;
                    end else if (i_in.ident != '1) begin
                        n_state = tws_pkg::ST_SCAN;
                    end
                end
            end
            tws_pkg::ST_SCAN: begin
                if (r_pend && (w_hit_any || r_chk == LAST_SLOT)) begin
                    n_state = tws_pkg::ST_APP_RD;
                end
            end
            tws_pkg::ST_APP_RD: begin
                n_state = tws_pkg::ST_APP_WR;
            end
            tws_pkg::ST_APP_WR: begin
                n_state = tws_pkg::ST_IDLE;
            end
            tws_pkg::ST_TICK_RD: begin
                n_state = tws_pkg::ST_TICK_EMIT;
            end
            tws_pkg::ST_TICK_EMIT: begin
                if (!w_cur_nz || (w_load && w_last)) begin
                    n_state = tws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tws_pkg::ST_CLEAR;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_scan      = r_scan;
        n_chk       = r_chk;
        n_pend      = r_pend;
        n_cur       = r_cur;
        n_tag       = r_tag;
        n_dmod      = r_dmod;
        n_idx       = r_idx;
        n_out_vld   = r_out_vld;
        n_out_ident = r_out_ident;
        n_out_last  = r_out_last;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_scan;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_cur;
        w_wr_data   = '0;

        if (o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            tws_pkg::ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_scan;
                n_scan    = r_scan + 1'b1;
            end
            tws_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_tag  = i_in.ident + 1'b1;
                    n_dmod = f_mod_slots(i_in.delay);
                    n_scan = '0;
                    n_pend = 1'b0;
                    n_idx  = '0;
                end
            end
            tws_pkg::ST_SCAN: begin
                if (r_pend && w_hit_any) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_chk;
                    w_wr_data = w_removed;
                end else if (!(r_pend && r_chk == LAST_SLOT)) begin
                    // next row read overlaps the compare of the previous one
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_scan;
                    n_chk     = r_scan;
                    n_pend    = 1'b1;
                    n_scan    = r_scan + 1'b1;
                end
            end
            tws_pkg::ST_APP_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_target;
            end
            tws_pkg::ST_APP_WR: begin
                // full slot drops the identifier
                w_wr_en   = w_free_any;
                w_wr_addr = w_target;
                w_wr_data = w_appended;
            end
            tws_pkg::ST_TICK_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_cur;
            end
            tws_pkg::ST_TICK_EMIT: begin
                if (!w_cur_nz) begin
                    w_wr_en = 1'b1;
                    n_cur   = w_cur_next;
                end else if (w_load) begin
                    n_out_vld   = 1'b1;
                    n_out_ident = w_sel_ent - 1'b1;
                    n_out_last  = w_last;
                    n_idx       = r_idx + 1'b1;
                    if (w_last) begin
                        w_wr_en = 1'b1;
                        n_cur   = w_cur_next;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tws_pkg::ST_CLEAR;
            r_scan    <= '0;
            r_pend    <= 1'b0;
            r_cur     <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scan    <= n_scan;
            r_pend    <= n_pend;
            r_cur     <= n_cur;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk       <= n_chk;
        r_tag       <= n_tag;
        r_dmod      <= n_dmod;
        r_out_ident <= n_out_ident;
        r_out_last  <= n_out_last;
    end

    `TWS_ASSERT_SAME(a_no_empty_code_out, i_clk, i_rst_n, r_out_vld, r_out_ident != '1, "emitted identifier came from an empty entry")
    `TWS_ASSERT_NEXT(a_last_ends_tick, i_clk, i_rst_n, w_load && w_last, r_state == tws_pkg::ST_IDLE, "tick did not finish after its last beat")
    `TWS_ASSERT_SAME(a_beat_from_tick, i_clk, i_rst_n, $past(i_rst_n) && r_out_vld && !$past(r_out_vld), $past(r_state == tws_pkg::ST_TICK_EMIT), "output beat loaded outside a tick")
    `TWS_ASSERT_SAME(a_slot_moves_on_tick, i_clk, i_rst_n, $past(i_rst_n) && !$stable(r_cur), $past(r_state == tws_pkg::ST_TICK_EMIT), "current slot moved outside a tick")

endmodule

`default_nettype wire
